// ===== rtl/core/rgba_max_alpha_blend_assert.svh =====
// Assertion macros for the RGBA max-alpha blend core.
// No dependencies; include this file in any module that asserts.
`ifndef RGBA_MAX_ALPHA_BLEND_ASSERT_SVH
`define RGBA_MAX_ALPHA_BLEND_ASSERT_SVH
`ifndef SYNTHESIS
// Implication in the same cycle.
`define RMAB_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("rgba_max_alpha_blend: assertion failed");
// Implication in the next cycle.
`define RMAB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("rgba_max_alpha_blend: assertion failed");
`else
`define RMAB_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RMAB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/rmab_pkg.sv =====
// Package for the RGBA max-alpha blend core: widths, constants and the
// restoring-divider step function. No dependencies.
package rmab_pkg;

  localparam int NUM_CH         = 3;   // red, green, blue
  localparam int W_PIX          = 8;
  localparam int W_WGT          = 16;  // 8x8 product
  localparam int W_PROD         = 24;  // 8x16 product
  localparam int W_NUM          = W_PROD + 1;
  localparam int W_REM          = W_PROD;  // remainder below 256 * divisor
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = W_PIX / BITS_PER_STAGE;
  localparam int NUM_STAGES     = 3 + DIV_STAGES;
  localparam int W_SH           = $clog2(W_PIX);

  localparam logic [W_PIX-1:0] FULL_SCALE = 8'd255;

  typedef struct packed {
    logic             hit;
    logic [W_REM-1:0] rem;
  } div_res_t;

  // One restoring step: subtract the shifted divisor when it fits.
  function automatic div_res_t div_step(input logic [W_REM-1:0] rem,
                                        input logic [W_WGT-1:0] dvs,
                                        input logic [W_SH-1:0]  sh);
    logic [W_REM-1:0] dsh;
    div_res_t         res;
    dsh = W_REM'(dvs) << sh;
    res.hit = (rem >= dsh);
    res.rem = res.hit ? (rem - dsh) : rem;
    return res;
  endfunction

endpackage

// ===== rtl/core/rgba_max_alpha_blend.sv =====
// Top level of the RGBA max-alpha blend core: weight, multiply, sum and a
// pipelined restoring divider. Depends on rmab_pkg and the assert header.
//
// Channel   Dir  Width  Contents (lowest bits first)
// s_axis    in   64     src r,g,b,a then dst r,g,b,a, 8 bits each
// m_axis    out  32     out r,g,b,a, 8 bits each
//
// Throughput is one pixel pair per cycle while m_axis does not stall. The stages are:
// weights, products, sum with saturation check, then four divider stages that each
// resolve two of the eight quotient bits.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on m_axis freezes all stages together, so nothing is lost or
// repeated, and s_axis stays ready while the output stage can advance.
`include "rgba_max_alpha_blend_assert.svh"

module rgba_max_alpha_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
  // dst_alpha
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata_o
);

  localparam int NumCh = rmab_pkg::NUM_CH;
  localparam int WPix  = rmab_pkg::W_PIX;
  localparam int WWgt  = rmab_pkg::W_WGT;
  localparam int WProd = rmab_pkg::W_PROD;
  localparam int WNum  = rmab_pkg::W_NUM;
  localparam int WRem  = rmab_pkg::W_REM;
  localparam int NDiv  = rmab_pkg::DIV_STAGES;
  localparam int NStg  = rmab_pkg::NUM_STAGES;
  localparam int BPS   = rmab_pkg::BITS_PER_STAGE;

  // Stage valid bits, one per register stage; the last one is the output.
  logic [NStg-1:0] vld_q;
  logic            adv;

  // Whole pipe advances unless the output holds an untaken result.
  assign adv             = !vld_q[NStg-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: unpack, alpha max, weights and divisor
  // ---------------------------------------------------------------------
  logic [WPix-1:0]             src_a, dst_a, amax_d;
  logic [WWgt-1:0]             wd_d, ws_d, dvs_d;
  logic [NumCh-1:0][WPix-1:0]  sc_d, dc_d;

  always_comb begin
    src_a = s_axis_tdata_i[31:24];
    dst_a = s_axis_tdata_i[63:56];
    sc_d  = s_axis_tdata_i[23:0];
    dc_d  = s_axis_tdata_i[55:32];
    amax_d = (dst_a > src_a) ? dst_a : src_a;
    wd_d   = WWgt'(rmab_pkg::FULL_SCALE - src_a) * WWgt'(dst_a);
    ws_d   = WWgt'(src_a) * WWgt'(rmab_pkg::FULL_SCALE);
    // Both alphas zero: force the divisor to one, weights are zero anyway.
    dvs_d  = (amax_d == '0) ? WWgt'(1)
                            : WWgt'(amax_d) * WWgt'(rmab_pkg::FULL_SCALE);
  end

  logic [NumCh-1:0][WPix-1:0] s1_sc_q, s1_dc_q;
  logic [WWgt-1:0]            s1_wd_q, s1_ws_q, s1_dvs_q;
  logic [WPix-1:0]            s1_amax_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sc_q   <= sc_d;
      s1_dc_q   <= dc_d;
      s1_wd_q   <= wd_d;
      s1_ws_q   <= ws_d;
      s1_dvs_q  <= dvs_d;
      s1_amax_q <= amax_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: weighted products, one pair of multipliers per channel
  // ---------------------------------------------------------------------
  logic [NumCh-1:0][WProd-1:0] pd_d, ps_d;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      pd_d[c] = WProd'(s1_dc_q[c]) * WProd'(s1_wd_q);
      ps_d[c] = WProd'(s1_sc_q[c]) * WProd'(s1_ws_q);
    end
  end

  logic [NumCh-1:0][WProd-1:0] s2_pd_q, s2_ps_q;
  logic [WWgt-1:0]             s2_dvs_q;
  logic [WPix-1:0]             s2_amax_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pd_q   <= pd_d;
      s2_ps_q   <= ps_d;
      s2_dvs_q  <= s1_dvs_q;
      s2_amax_q <= s1_amax_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: sum, and flag quotients above full scale before dividing.
  // Below 256 * divisor the numerator fits the remainder width.
  // ---------------------------------------------------------------------
  logic [NumCh-1:0][WNum-1:0] num_d;
  logic [NumCh-1:0]           sat_d;
  logic [NumCh-1:0][WRem-1:0] rem0_d;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      num_d[c]  = WNum'(s2_pd_q[c]) + WNum'(s2_ps_q[c]);
      sat_d[c]  = (num_d[c] >= WNum'({s2_dvs_q, {WPix{1'b0}}}));
      rem0_d[c] = num_d[c][WRem-1:0];
    end
  end

  // Divider pipe: index 0 is stage 3, index NDiv is the output stage.
  logic [NumCh-1:0][WRem-1:0] rem_q  [NDiv+1];
  logic [NumCh-1:0][WPix-1:0] quo_q  [NDiv+1];
  logic [NumCh-1:0]           sat_q  [NDiv+1];
  logic [WWgt-1:0]            dvs_q  [NDiv+1];
  logic [WPix-1:0]            amax_q [NDiv+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= rem0_d;
      quo_q[0]  <= '0;
      sat_q[0]  <= sat_d;
      dvs_q[0]  <= s2_dvs_q;
      amax_q[0] <= s2_amax_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4 to 7: restoring division, two quotient bits per stage,
  // most significant first; bits shift in from the bottom.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NDiv; k++) begin : g_div
    logic [NumCh-1:0][WRem-1:0] rem_d;
    logic [NumCh-1:0][WPix-1:0] quo_d;

    always_comb begin
      rmab_pkg::div_res_t step;
      rem_d = rem_q[k];
      quo_d = quo_q[k];
      for (int c = 0; c < NumCh; c++) begin
        for (int b = 0; b < BPS; b++) begin
          step     = rmab_pkg::div_step(rem_d[c], dvs_q[k],
                                        rmab_pkg::W_SH'(WPix - 1 - k * BPS - b));
          rem_d[c] = step.rem;
          quo_d[c] = {quo_d[c][WPix-2:0], step.hit};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rem_q[k+1]  <= rem_d;
        quo_q[k+1]  <= quo_d;
        sat_q[k+1]  <= sat_q[k];
        dvs_q[k+1]  <= dvs_q[k];
        amax_q[k+1] <= amax_q[k];
      end
    end
  end

  // Output: clamp colors whose quotient passed full scale.
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      m_axis_tdata_o[c*WPix +: WPix] = sat_q[NDiv][c] ? rmab_pkg::FULL_SCALE
                                                      : quo_q[NDiv][c];
    end
    m_axis_tdata_o[NumCh*WPix +: WPix] = amax_q[NDiv];
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Zero output alpha means both weights were zero: black result.
  `RMAB_ASSERT_IMPL(a_zero_alpha_black, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[31:24] == '0), m_axis_tdata_o[23:0] == '0)
  // An unclamped red quotient leaves a remainder below the divisor.
  `RMAB_ASSERT_IMPL(a_div_rem_bound, clk_i, rst_ni, vld_q[NStg-1] && !sat_q[NDiv][0], rem_q[NDiv][0] < WRem'(dvs_q[NDiv]))
  // A stalled pipe keeps every stage's occupancy.
  `RMAB_ASSERT_NEXT(a_stall_freeze, clk_i, rst_ni, !adv, $stable(vld_q))

endmodule

// ===== sim/blend_checker.sv =====
// Checker for the RGBA max-alpha blend core: predicts each blended pixel
// from the accepted input pair and compares it with the output stream.
// Depends on rmab_pkg for the full-scale constant.
module blend_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pix_valid_i,
  input  logic        pix_ready_i,
  input  logic [63:0] pix_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  output int          pending_o,
  output int          mismatch_o
);

  // Red sits in the lowest byte, alpha in the highest.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  rgba_t blended_q[$];
  int    fails = 0;

  function automatic logic [7:0] blend_channel(logic [7:0] dc, logic [7:0] sc,
                                               logic [31:0] wd, logic [31:0] ws,
                                               logic [31:0] dv);
    logic [31:0] q;
    q = (32'(dc) * wd + 32'(sc) * ws) / dv;
    return (q > 32'(rmab_pkg::FULL_SCALE)) ? rmab_pkg::FULL_SCALE : q[7:0];
  endfunction

  // Source over destination, normalized by the larger alpha.
  function automatic rgba_t blend_over(rgba_t s, rgba_t d);
    logic [31:0] wd, ws, dv;
    logic [7:0]  amax;
    rgba_t       o;
    wd   = (32'(rmab_pkg::FULL_SCALE) - 32'(s.alpha)) * 32'(d.alpha);
    ws   = 32'(s.alpha) * 32'(rmab_pkg::FULL_SCALE);
    amax = (d.alpha > s.alpha) ? d.alpha : s.alpha;
    dv   = 32'(amax) * 32'(rmab_pkg::FULL_SCALE);
    if (dv == 0) dv = 1;
    o.red   = blend_channel(d.red,   s.red,   wd, ws, dv);
    o.green = blend_channel(d.green, s.green, wd, ws, dv);
    o.blue  = blend_channel(d.blue,  s.blue,  wd, ws, dv);
    o.alpha = amax;
    return o;
  endfunction

  task automatic note_failure(string msg);
    fails++;
    if (fails <= 10) $display("%t blend checker: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_o  <= 0;
      mismatch_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (blended_q.size() == 0) begin
          note_failure($sformatf("unexpected result %h", out_data_i));
        end else begin
          rgba_t want, got;
          want = blended_q.pop_front();
          got  = out_data_i;
          check_field("red",   want.red,   got.red);
          check_field("green", want.green, got.green);
          check_field("blue",  want.blue,  got.blue);
          check_field("alpha", want.alpha, got.alpha);
        end
      end
      if (pix_valid_i && pix_ready_i)
        blended_q.push_back(blend_over(pix_data_i[31:0], pix_data_i[63:32]));
      pending_o  <= blended_q.size();
      mismatch_o <= fails;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the RGBA max-alpha blend core: drives pixel pairs and
// output backpressure, runs a watchdog and prints the verdict.
// Depends on rgba_max_alpha_blend and blend_checker.
module tb;

  localparam int NUM_RANDOM = 650;
  localparam int IDLE_LIMIT = 5000;  // cycles without any transfer
  localparam int DRAIN_WAIT = 16;    // well past the pipeline depth

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready_o;
  logic        m_tvalid_o;
  logic [31:0] m_tdata_o;
  int          pending;
  int          mismatches;
  bit          no_idle = 1'b0;  // set to run a stretch without any gaps

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  rgba_max_alpha_blend dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata_o)
  );

  blend_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_tvalid),
    .pix_ready_i (s_tready_o),
    .pix_data_i  (s_tdata),
    .out_valid_i (m_tvalid_o),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata_o),
    .pending_o   (pending),
    .mismatch_o  (mismatches)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Bias toward the alpha corners: transparent, opaque and their neighbors.
  function automatic logic [7:0] rand_alpha();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Pack lowest byte first: src r,g,b,a then dst r,g,b,a.
  function automatic logic [63:0] pixel_pair(logic [7:0] sr, logic [7:0] sg,
                                             logic [7:0] sb, logic [7:0] sa,
                                             logic [7:0] dr, logic [7:0] dg,
                                             logic [7:0] db, logic [7:0] da);
    return {da, db, dg, dr, sa, sb, sg, sr};
  endfunction

  // Present one pixel pair, hold it until the transfer, then maybe idle.
  // Called right after a rising edge; leaves valid high when no gap follows
  // so back-to-back transfers never drop valid within a step.
  task automatic send_pair(logic [63:0] px);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};  // garbage while idle
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Output backpressure: stall at random, never while no_idle is set.
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      stall = pick_gap();
      if (stall == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] sa, da;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: all zero, all ones, both alphas transparent,
    // one side opaque, overflowing sums that must saturate.
    send_pair(pixel_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair({64{1'b1}});
    send_pair(pixel_pair(255, 128, 1, 0, 77, 255, 200, 0));
    send_pair(pixel_pair(10, 20, 30, 255, 200, 210, 220, 0));
    send_pair(pixel_pair(10, 20, 30, 0, 200, 210, 220, 255));
    send_pair(pixel_pair(255, 255, 255, 128, 255, 255, 255, 128));
    send_pair(pixel_pair(255, 0, 255, 128, 0, 255, 255, 128));
    send_pair(pixel_pair(255, 255, 255, 200, 255, 255, 255, 100));
    send_pair(pixel_pair(255, 255, 255, 1, 255, 255, 255, 1));
    send_pair(pixel_pair(255, 255, 255, 1, 255, 255, 255, 255));
    send_pair(pixel_pair(255, 255, 255, 254, 255, 255, 255, 255));
    send_pair(pixel_pair(0, 0, 0, 255, 255, 255, 255, 255));
    send_pair(pixel_pair(255, 255, 255, 255, 0, 0, 0, 255));
    send_pair(pixel_pair(1, 2, 3, 255, 4, 5, 6, 1));
    send_pair(pixel_pair(170, 85, 170, 85, 85, 170, 85, 170));
    send_pair(pixel_pair(85, 170, 85, 170, 170, 85, 170, 85));
    send_pair(pixel_pair(255, 255, 255, 127, 255, 255, 255, 127));
    send_pair(pixel_pair(0, 255, 0, 1, 255, 0, 255, 0));
    send_pair(pixel_pair(255, 255, 255, 0, 0, 0, 0, 1));

    // Random pairs; a middle stretch runs with no gaps on either side.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_idle = (i >= 300 && i < 380);
      sa = rand_alpha();
      da = ($urandom_range(0, 4) == 0) ? sa : rand_alpha();
      send_pair(pixel_pair(rand_color(), rand_color(), rand_color(), sa,
                           rand_color(), rand_color(), rand_color(), da));
    end
    s_tvalid <= 1'b0;
    no_idle = 1'b0;

    // Drain: wait for every expected pixel, then let the pipeline settle.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== rgba_max_alpha_blend.f =====
+incdir+rtl/core
rtl/core/rmab_pkg.sv
rtl/core/rgba_max_alpha_blend.sv
sim/blend_checker.sv
sim/tb.sv
